/* src/eror_pkg.sv */
package eror_pkg;

    // Deepest window the history memory holds
    localparam int MAX_WINDOW = 512;

    // Field and datapath widths
    localparam int SAMPLE_W  = 32;
    localparam int ENERGY_W  = 48;
    localparam int WLEN_W    = 10;
    localparam int POS_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W     = ENERGY_W + POS_W;
    localparam int FRAC_W    = 16;
    localparam int NUM_W     = ENERGY_W + FRAC_W;
    localparam int DIV_CW    = $clog2(NUM_W);
    localparam int VEL_W     = 32;

    // Step queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET = WLEN_W'(20);

    // One finished step handed from front to back
    typedef struct packed {
        logic                clr;
        logic [ENERGY_W-1:0] energy;
    } t_step_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DIV,
        ST_OUT
    } t_back_state;

    // Map the register value onto the usable window range
    function automatic logic [CNT_W-1:0] eff_window(input logic [WLEN_W-1:0] len);
        logic [31:0] l;
        l = 32'(len);
        if (l == 32'd0) begin
            l = 32'd1;
        end else if (l > 32'(MAX_WINDOW)) begin
            l = 32'(MAX_WINDOW);
        end
        return CNT_W'(l);
    endfunction

endpackage

/* src/eror_if.sv */
interface eror_in_if import eror_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] imf_sample;
    logic                       step_end;
    logic                       series_start;

    modport source (output valid, output imf_sample, output step_end,
                    output series_start, input ready);
    modport sink   (input valid, input imf_sample, input step_end,
                    input series_start, output ready);
endinterface

interface eror_out_if import eror_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] velocity;
    logic                    defined;

    modport source (output valid, output velocity, output defined, input ready);
    modport sink   (input valid, input velocity, input defined, output ready);
endinterface

/* src/eror_front.sv */
module eror_front import eror_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    eror_in_if.sink     i_sample,
    input  logic        i_full,
    output logic        o_push,
    output t_step_entry o_entry
);

    logic                r_a_valid;
    logic [SAMPLE_W-1:0] r_a_mag;
    logic                r_a_end;
    logic                r_a_start;

    logic                r_b_valid;
    logic [ENERGY_W-1:0] r_b_sq;
    logic                r_b_end;
    logic                r_b_start;

    logic [ENERGY_W-1:0] r_energy;
    logic                r_clr;

    logic [SAMPLE_W-1:0] n_mag;
    logic [2*SAMPLE_W-1:0] prod;
    logic [ENERGY_W-1:0] base;
    logic [ENERGY_W:0]   acc;
    logic [ENERGY_W-1:0] acc_sat;
    logic                b_adv;
    logic                a_adv;
    logic                a_ready;

    // Handshake through the two stages; stall only on a step end with a full queue
    assign b_adv   = r_b_valid && !(r_b_end && i_full);
    assign a_adv   = r_a_valid && (!r_b_valid || b_adv);
    assign a_ready = !r_a_valid || a_adv;
    assign i_sample.ready = a_ready;

    // Magnitude of the sample; the most negative value maps to 2^31
    assign n_mag = i_sample.imf_sample[SAMPLE_W-1]
                 ? SAMPLE_W'(-i_sample.imf_sample) : i_sample.imf_sample;

    // Square in Q32.32, truncate to Q32.16
    assign prod = r_a_mag * r_a_mag;

    // Add into the step energy, starting fresh on a series start
    assign base    = r_b_start ? '0 : r_energy;
    assign acc     = {1'b0, base} + {1'b0, r_b_sq};
    assign acc_sat = acc[ENERGY_W] ? '1 : acc[ENERGY_W-1:0];

    assign o_push         = r_b_valid && r_b_end && !i_full;
    assign o_entry.energy = acc_sat;
    assign o_entry.clr    = r_clr || r_b_start;

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_sample.valid;
            end
            if (!r_b_valid || b_adv) begin
                r_b_valid <= a_adv;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (a_ready && i_sample.valid) begin
            r_a_mag   <= n_mag;
            r_a_end   <= i_sample.step_end;
            r_a_start <= i_sample.series_start;
        end
        if (a_adv) begin
            r_b_sq    <= prod[FRAC_W +: ENERGY_W];
            r_b_end   <= r_a_end;
            r_b_start <= r_a_start;
        end
    end

    // Step accumulator; hand over and restart at each step end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_energy <= '0;
            r_clr    <= 1'b0;
        end else if (b_adv) begin
            if (r_b_end) begin
                r_energy <= '0;
                r_clr    <= 1'b0;
            end else begin
                r_energy <= acc_sat;
                r_clr    <= r_clr || r_b_start;
            end
        end
    end

endmodule

/* src/eror_fifo.sv */
module eror_fifo import eror_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_step_entry i_entry,
    input  logic        i_pop,
    output t_step_entry o_entry,
    output logic        o_full,
    output logic        o_empty
);

    t_step_entry          r_slot [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_AW:0]     r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_slot[r_rd];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the incoming step
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_entry;
        end
    end

endmodule

/* src/eror_div.sv */
module eror_div import eror_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [SUM_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_den;

    logic [SUM_W:0]    rem_sh;
    logic              fits;
    logic [SUM_W:0]    rem_sub;

    // One restoring step: shift in the next numerator bit, subtract if it fits
    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign fits    = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    assign o_done = r_done;
    assign o_quo  = r_num;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath; quotient bits shift in behind the numerator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], fits};
            r_rem <= fits ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
        end
    end

endmodule

/* src/eror_back.sv */
module eror_back import eror_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic [WLEN_W-1:0] i_window_len,
    input  logic              i_empty,
    input  t_step_entry       i_entry,
    output logic              o_pop,
    eror_out_if.source        o_result
);

    localparam logic [NUM_W-1:0] POS_LIMIT = NUM_W'(32'h7FFF_FFFF);
    localparam logic [NUM_W-1:0] NEG_LIMIT = NUM_W'(32'h8000_0000);

    t_back_state r_state;
    t_back_state n_state;

    logic [ENERGY_W-1:0] r_hist [MAX_WINDOW];
    logic [ENERGY_W-1:0] r_rd_data;

    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;
    logic [POS_W-1:0]    r_pos;
    logic [ENERGY_W-1:0] r_e;
    logic                r_neg;
    logic [VEL_W-1:0]    r_vel;
    logic                r_def;

    logic                r_ovalid;
    logic [VEL_W-1:0]    r_out_vel;
    logic                r_out_def;

    logic                rd_en;
    logic                calc;
    logic                div_start;
    logic                out_load;

    logic [CNT_W-1:0]    w;
    logic                warm;
    logic                e_lt_h;
    logic [ENERGY_W-1:0] mag;
    logic                need_div;
    logic [CNT_W-1:0]    pos_inc;

    logic                div_done;
    logic [NUM_W-1:0]    div_quo;
    logic [VEL_W-1:0]    qclip;
    logic [VEL_W-1:0]    vel_sat;

    // Window update terms for the step being processed
    always_comb begin
        w        = eff_window(i_window_len);
        warm     = (r_count < w);
        e_lt_h   = (r_e < r_rd_data);
        mag      = e_lt_h ? (r_rd_data - r_e) : (r_e - r_rd_data);
        need_div = !warm && (r_sum != '0);
        pos_inc  = CNT_W'(r_pos) + 1'b1;
    end

    // Clamp the quotient and apply the sign
    always_comb begin
        if (!r_neg) begin
            qclip   = (div_quo > POS_LIMIT) ? POS_LIMIT[VEL_W-1:0] : div_quo[VEL_W-1:0];
            vel_sat = qclip;
        end else begin
            qclip   = (div_quo > NEG_LIMIT) ? NEG_LIMIT[VEL_W-1:0] : div_quo[VEL_W-1:0];
            vel_sat = ~qclip + 1'b1;
        end
    end

    eror_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({mag, FRAC_W'(0)}),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_CALC;
            ST_CALC: n_state = need_div ? ST_DIV : ST_OUT;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || o_result.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        calc      = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE: o_pop = !i_empty;
            ST_READ: rd_en = 1'b1;
            ST_CALC: begin
                calc      = 1'b1;
                div_start = need_div;
            end
            ST_DIV:  ;
            ST_OUT:  out_load = !r_ovalid || o_result.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // History ring
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_hist[r_pos];
        end
        if (calc) begin
            r_hist[r_pos] <= r_e;
        end
    end

    // Window sum, fill count and ring position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sum   <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else if (o_pop && i_entry.clr) begin
            r_sum   <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else if (calc) begin
            if (warm) begin
                r_sum   <= r_sum + SUM_W'(r_e);
                r_count <= r_count + 1'b1;
            end else begin
                r_sum <= r_sum - SUM_W'(r_rd_data) + SUM_W'(r_e);
            end
            r_pos <= (pos_inc >= w) ? '0 : pos_inc[POS_W-1:0];
        end
    end

    // Step payload and result
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_e <= i_entry.energy;
        end
        if (calc) begin
            r_neg <= e_lt_h;
            r_vel <= '0;
            r_def <= 1'b0;
        end else if (r_state == ST_DIV && div_done) begin
            r_vel <= vel_sat;
            r_def <= 1'b1;
        end
    end

    // Output register; holds the beat while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_vel <= r_vel;
            r_out_def <= r_def;
        end
    end

    assign o_result.valid    = r_ovalid;
    assign o_result.velocity = r_out_vel;
    assign o_result.defined  = r_out_def;

endmodule

/* src/energy_rolling_rate_of_change.sv */
// Rolling-window energy rate of change.
// Input channel i_sample carries one IMF sample per beat (signed Q16.16) with
// step_end marking the last sample of a time step and series_start restarting
// the window. Each step end yields one beat on o_result: velocity (signed
// Q16.16, saturated) and defined.
// Front: a 2-stage square-and-accumulate pipeline takes one sample per cycle
// until the 4-entry queue fills, and pushes finished step energies into it.
// Back: per step, it pops the queue, reads the history memory, updates the
// window, then waits on the bit-serial divider once the window is full and
// its sum is nonzero, and loads the output register; it finishes one step
// before it pops the next. The divider sets the sustained step rate; samples
// flow at one per cycle until the queue fills.
// Reset sets window_len to 20 (APB address 0) and empties the series; the
// history memory is not cleared, since only entries written in the current
// series are read. Writing window_len also restarts the series.
// While the receiver stalls, the output register holds its beat and the back
// part stops at its next result; the queue then fills and ready drops.
module energy_rolling_rate_of_change import eror_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    eror_in_if.sink           i_sample,
    eror_out_if.source        o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [WLEN_W-1:0] r_window_len;
    logic              cfg_wr;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    t_step_entry       push_entry;
    t_step_entry       head_entry;

    // Register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LEN);
    assign prdata = (paddr[2] == REG_WINDOW_LEN) ? APB_DW'(r_window_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_LEN_RESET;
        end else if (cfg_wr) begin
            r_window_len <= pwdata[WLEN_W-1:0];
        end
    end

    eror_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_wr),
        .i_sample (i_sample),
        .i_full   (full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    eror_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (full),
        .o_empty (empty)
    );

    eror_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (cfg_wr),
        .i_window_len (r_window_len),
        .i_empty      (empty),
        .i_entry      (head_entry),
        .o_pop        (pop),
        .o_result     (o_result)
    );

endmodule
